### sv/cave_automaton_smoothing_step_assert.svh
// assertion helpers used by cas_cell
`ifndef CAVE_AUTOMATON_SMOOTHING_STEP_ASSERT_SVH
`define CAVE_AUTOMATON_SMOOTHING_STEP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CAS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/cas_pkg.sv
package cas_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_PASSES = 8;
  localparam int WALL_LIMIT = 3;

  localparam int ROW_FIELD_W  = 64;
  localparam int ROW_WIDTH_W  = 7;
  localparam int PASS_CNT_W   = 4;
  localparam int CFG_DATA_W   = 7;
  localparam int PASS_W       = $clog2(MAX_PASSES + 1);

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = ROW_WIDTH_W'(64);
  localparam logic [PASS_CNT_W-1:0]  PASS_CNT_RST  = PASS_CNT_W'(1);

  // register indexes
  localparam logic CFG_ROW_WIDTH  = 1'b0;
  localparam logic CFG_PASS_COUNT = 1'b1;

  typedef logic [MAX_WIDTH-1:0] row_bits_t;

  typedef struct packed {
    row_bits_t cells;
    logic      last;
  } cas_row_t;

  // one smoothing pass over a row; columns outside the mask count as walls
  function automatic row_bits_t smooth_row(row_bits_t up, row_bits_t mid,
                                           row_bits_t down, row_bits_t mask);
    logic [MAX_WIDTH+1:0] up_p;
    logic [MAX_WIDTH+1:0] mid_p;
    logic [MAX_WIDTH+1:0] down_p;
    logic [3:0]           cnt;
    row_bits_t            res;
    up_p   = {1'b1, up | ~mask, 1'b1};
    mid_p  = {1'b1, mid | ~mask, 1'b1};
    down_p = {1'b1, down | ~mask, 1'b1};
    res    = '0;
    for (int c = 0; c < MAX_WIDTH; c++) begin
      cnt = {3'b000, up_p[c]} + {3'b000, up_p[c+1]} + {3'b000, up_p[c+2]}
          + {3'b000, mid_p[c]} + {3'b000, mid_p[c+2]}
          + {3'b000, down_p[c]} + {3'b000, down_p[c+1]} + {3'b000, down_p[c+2]};
      res[c] = (cnt >= 4'(WALL_LIMIT));
    end
    return res & mask;
  endfunction

endpackage

### sv/cas_cell.sv
`include "cave_automaton_smoothing_step_assert.svh"

module cas_cell
  import cas_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  row_bits_t width_mask,
  input  logic      in_valid,
  input  cas_row_t  in_row,
  output logic      in_ready,
  output logic      out_valid,
  output cas_row_t  out_row,
  input  logic      out_ready
);

  row_bits_t above_r, above_nxt;
  row_bits_t mid_r, mid_nxt;
  logic      primed_r, primed_nxt;
  logic      pend_r, pend_nxt;
  logic      out_valid_r, out_valid_nxt;
  cas_row_t  out_row_r, out_row_nxt;

  logic      out_free;
  logic      in_fire;
  row_bits_t mid_sel;
  row_bits_t down_sel;
  row_bits_t smoothed;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !pend_r && out_free;
  assign in_fire  = in_valid && in_ready;

  // one shared kernel: held row with new row below, new row alone, or flush
  assign mid_sel  = primed_r ? mid_r : in_row.cells;
  assign down_sel = (pend_r || !primed_r) ? '1 : in_row.cells;
  assign smoothed = smooth_row(above_r, mid_sel, down_sel, width_mask);

  always_comb begin
    above_nxt     = above_r;
    mid_nxt       = mid_r;
    primed_nxt    = primed_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_row_nxt   = out_row_r;
    if (pend_r) begin
      if (out_free) begin
        out_valid_nxt     = 1'b1;
        out_row_nxt.cells = smoothed;
        out_row_nxt.last  = 1'b1;
        above_nxt         = '1;
        mid_nxt           = '0;
        primed_nxt        = 1'b0;
        pend_nxt          = 1'b0;
      end
    end else if (in_fire) begin
      if (!primed_r) begin
        if (in_row.last) begin
          // single-row tail: smooth at once between walls
          out_valid_nxt     = 1'b1;
          out_row_nxt.cells = smoothed;
          out_row_nxt.last  = 1'b1;
          above_nxt         = '1;
          mid_nxt           = '0;
        end else begin
          mid_nxt    = in_row.cells;
          primed_nxt = 1'b1;
        end
      end else begin
        out_valid_nxt     = 1'b1;
        out_row_nxt.cells = smoothed;
        out_row_nxt.last  = 1'b0;
        above_nxt         = mid_r;
        mid_nxt           = in_row.cells;
        pend_nxt          = in_row.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_r     <= '1;
      mid_r       <= '0;
      primed_r    <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      above_r     <= above_nxt;
      mid_r       <= mid_nxt;
      primed_r    <= primed_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_row_r <= out_row_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;

  `CAS_ASSERT_SAME(a_pend_primed, pend_r, primed_r && out_valid_r,
                   "flush pending without a held row or first result")
  `CAS_ASSERT_NEXT(a_last_flush, in_fire && primed_r && in_row.last, pend_r,
                   "last row into a primed stage did not schedule a flush")
  `CAS_ASSERT_SAME(a_last_clears, out_valid_r && out_row_r.last && !pend_r,
                   !primed_r && (above_r == '1),
                   "stage not cleared after emitting the last row")

endmodule

### sv/cave_automaton_smoothing_step.sv
// channel | ports                                      | transfer when
// --------+--------------------------------------------+-------------------------
// input   | in_row_cells, in_last_row                  | in_valid && in_ready
// result  | out_cells, out_last                        | out_valid && out_ready
// config  | cfg_index, cfg_wdata                       | cfg_we
//
// accepts one row per cycle while nothing stalls; a row passes through the entry
// register, then each active stage in turn, and a stage holds one row back until
// the next arrives. a primed stage that takes a last row refuses input until it flushes.
// rst_n is synchronous: stages return to wall above, empty held row, not primed.
// out_ready low stalls the cascade back to in_ready through each stage's ready.
module cave_automaton_smoothing_step
  import cas_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ROW_FIELD_W-1:0] in_row_cells,
  input  logic                   in_last_row,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ROW_FIELD_W-1:0] out_cells,
  output logic                   out_last,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // configuration registers
  logic [ROW_WIDTH_W-1:0] row_width_r;
  logic [PASS_CNT_W-1:0]  pass_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r  <= ROW_WIDTH_RST;
      pass_count_r <= PASS_CNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_WIDTH:  row_width_r  <= cfg_wdata[ROW_WIDTH_W-1:0];
        CFG_PASS_COUNT: pass_count_r <= cfg_wdata[PASS_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // width 0 acts as 1, anything past the row acts as a full row
  logic [ROW_WIDTH_W-1:0] eff_width;
  row_bits_t              width_mask;
  logic [PASS_W-1:0]      eff_passes;

  always_comb begin
    if (row_width_r == '0) begin
      eff_width = ROW_WIDTH_W'(1);
    end else if (row_width_r > ROW_WIDTH_W'(MAX_WIDTH)) begin
      eff_width = ROW_WIDTH_W'(MAX_WIDTH);
    end else begin
      eff_width = row_width_r;
    end
    if (eff_width >= ROW_WIDTH_W'(MAX_WIDTH)) begin
      width_mask = '1;
    end else begin
      width_mask = (MAX_WIDTH'(1) << eff_width) - MAX_WIDTH'(1);
    end
    if (pass_count_r > PASS_CNT_W'(MAX_PASSES)) begin
      eff_passes = PASS_W'(MAX_PASSES);
    end else begin
      eff_passes = PASS_W'(pass_count_r);
    end
  end

  // entry register: masks the row and parts the input from the cascade
  logic     ent_valid_r, ent_valid_nxt;
  cas_row_t ent_row_r, ent_row_nxt;
  logic     ent_down_ready;
  logic     in_fire;

  assign in_ready = !ent_valid_r || ent_down_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    ent_valid_nxt = ent_valid_r && !ent_down_ready;
    ent_row_nxt   = ent_row_r;
    if (in_fire) begin
      ent_valid_nxt     = 1'b1;
      ent_row_nxt.cells = in_row_cells[MAX_WIDTH-1:0] & width_mask;
      ent_row_nxt.last  = in_last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
    end else begin
      ent_valid_r <= ent_valid_nxt;
    end
    ent_row_r <= ent_row_nxt;
  end

  // stage enables and the stage that feeds the result port
  logic [MAX_PASSES-1:0] stage_en;
  logic [MAX_PASSES-1:0] stage_tail;

  always_comb begin
    for (int s = 0; s < MAX_PASSES; s++) begin
      stage_en[s]   = (s < int'(eff_passes));
      stage_tail[s] = (int'(eff_passes) == s + 1);
    end
  end

  // the smoothing cascade
  logic [MAX_PASSES-1:0] cell_in_valid;
  logic [MAX_PASSES-1:0] cell_in_ready;
  logic [MAX_PASSES-1:0] cell_out_valid;
  logic [MAX_PASSES-1:0] cell_down_ready;
  cas_row_t              cell_in_row  [MAX_PASSES];
  cas_row_t              cell_out_row [MAX_PASSES];

  assign ent_down_ready = (eff_passes == '0) ? out_ready : cell_in_ready[0];

  for (genvar s = 0; s < MAX_PASSES; s++) begin : g_stage
    if (s == 0) begin : g_head
      assign cell_in_valid[s] = ent_valid_r && stage_en[s];
      assign cell_in_row[s]   = ent_row_r;
    end else begin : g_link
      assign cell_in_valid[s] = cell_out_valid[s-1] && stage_en[s];
      assign cell_in_row[s]   = cell_out_row[s-1];
    end

    if (s == MAX_PASSES - 1) begin : g_end
      assign cell_down_ready[s] = out_ready;
    end else begin : g_mid
      assign cell_down_ready[s] = stage_tail[s] ? out_ready : cell_in_ready[s+1];
    end

    cas_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .width_mask (width_mask),
      .in_valid   (cell_in_valid[s]),
      .in_row     (cell_in_row[s]),
      .in_ready   (cell_in_ready[s]),
      .out_valid  (cell_out_valid[s]),
      .out_row    (cell_out_row[s]),
      .out_ready  (cell_down_ready[s])
    );
  end

  // result port follows the last active stage, or the entry with no passes
  cas_row_t res_row;
  logic     res_valid;

  always_comb begin
    res_valid = ent_valid_r;
    res_row   = ent_row_r;
    for (int s = 0; s < MAX_PASSES; s++) begin
      if (stage_tail[s]) begin
        res_valid = cell_out_valid[s];
        res_row   = cell_out_row[s];
      end
    end
  end

  assign out_valid = res_valid;
  assign out_cells = ROW_FIELD_W'(res_row.cells);
  assign out_last  = res_row.last;

endmodule

### test/tb_top.sv
module tb_top;
  import cas_pkg::*;

  // run limits
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 160;
  localparam int SETTLE_CYCLES = 2 * MAX_PASSES + 24;  // entry reg + stage moves + flushes
  localparam int LONG_HOLD    = 200;
  localparam int HOLD_ROWS    = 24;

  localparam row_bits_t ALL_WALL = '1;

  // widths around the edges of the legal range, plus the clamped codes
  localparam logic [ROW_WIDTH_W-1:0] WIDTH_EDGES [6] = '{
    7'd0, 7'd1, 7'd2, 7'd64, 7'd65, 7'd127
  };

  typedef enum logic {STEP_ROW, STEP_CFG} step_kind_t;

  // one line of the directed table: either a register setting or one row transfer,
  // with a hand-written expectation where it is obvious
  typedef struct packed {
    step_kind_t                kind;
    logic [CFG_DATA_W-1:0]     width;
    logic [CFG_DATA_W-1:0]     passes;
    row_bits_t                 cells;
    logic                      last;
    logic                      typed;
    row_bits_t                 exp_cells;
    logic                      exp_last;
  } dir_step_t;

  localparam int NUM_STEPS = 28;

  dir_step_t directed_steps [NUM_STEPS] = '{
    // defaults after reset: width 64, one pass; single-row grids see walls above and below
    '{STEP_ROW, 7'd0, 7'd0, 64'h0, 1'b1, 1'b1, ALL_WALL, 1'b1},
    '{STEP_ROW, 7'd0, 7'd0, ALL_WALL, 1'b1, 1'b1, ALL_WALL, 1'b1},
    // short grid, all cases through the predictor
    '{STEP_ROW, 7'd0, 7'd0, 64'h0, 1'b0, 1'b0, 64'h0, 1'b0},
    '{STEP_ROW, 7'd0, 7'd0, ALL_WALL, 1'b0, 1'b0, 64'h0, 1'b0},
    '{STEP_ROW, 7'd0, 7'd0, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b0, 64'h0, 1'b0},
    // zero passes: rows go straight through
    '{STEP_CFG, 7'd64, 7'd0, 64'h0, 1'b0, 1'b0, 64'h0, 1'b0},
    '{STEP_ROW, 7'd0, 7'd0, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0, 1'b1, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0},
    '{STEP_ROW, 7'd0, 7'd0, 64'h5A5A_5A5A_5A5A_5A5A, 1'b1, 1'b1, 64'h5A5A_5A5A_5A5A_5A5A, 1'b1},
    // narrowest row; upper data bits of the pass register are dropped
    '{STEP_CFG, 7'd1, 7'h70, 64'h0, 1'b0, 1'b0, 64'h0, 1'b0},
    '{STEP_ROW, 7'd0, 7'd0, ALL_WALL, 1'b1, 1'b1, 64'h1, 1'b1},
    '{STEP_ROW, 7'd0, 7'd0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b1, 64'h0, 1'b1},
    // width code 0 acts as one column, full cascade
    '{STEP_CFG, 7'd0, 7'd8, 64'h0, 1'b0, 1'b0, 64'h0, 1'b0},
    '{STEP_ROW, 7'd0, 7'd0, 64'h1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{STEP_ROW, 7'd0, 7'd0, 64'h0, 1'b0, 1'b0, 64'h0, 1'b0},
    '{STEP_ROW, 7'd0, 7'd0, 64'h1, 1'b1, 1'b0, 64'h0, 1'b0},
    // both registers above their clamps; the last row releases the most rows
    '{STEP_CFG, 7'd127, 7'd15, 64'h0, 1'b0, 1'b0, 64'h0, 1'b0},
    '{STEP_ROW, 7'd0, 7'd0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 64'h0, 1'b0},
    '{STEP_ROW, 7'd0, 7'd0, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 64'h0, 1'b0},
    '{STEP_ROW, 7'd0, 7'd0, 64'h0, 1'b0, 1'b0, 64'h0, 1'b0},
    '{STEP_ROW, 7'd0, 7'd0, ALL_WALL, 1'b1, 1'b0, 64'h0, 1'b0},
    // settings change in the middle of a grid, held rows re-read at the new width
    '{STEP_CFG, 7'd64, 7'd3, 64'h0, 1'b0, 1'b0, 64'h0, 1'b0},
    '{STEP_ROW, 7'd0, 7'd0, 64'h0F0F_0000_F0F0_1248, 1'b0, 1'b0, 64'h0, 1'b0},
    '{STEP_ROW, 7'd0, 7'd0, 64'h8000_0001_0000_0180, 1'b0, 1'b0, 64'h0, 1'b0},
    '{STEP_CFG, 7'd10, 7'd5, 64'h0, 1'b0, 1'b0, 64'h0, 1'b0},
    '{STEP_ROW, 7'd0, 7'd0, 64'h0000_0000_0000_0213, 1'b1, 1'b0, 64'h0, 1'b0},
    '{STEP_CFG, 7'd3, 7'd2, 64'h0, 1'b0, 1'b0, 64'h0, 1'b0},
    '{STEP_ROW, 7'd0, 7'd0, 64'h2, 1'b0, 1'b0, 64'h0, 1'b0},
    '{STEP_ROW, 7'd0, 7'd0, 64'h5, 1'b1, 1'b0, 64'h0, 1'b0}
  };

  // dut ports; every input starts at a known value
  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [ROW_FIELD_W-1:0] in_row_cells = '0;
  logic                  in_last_row  = 1'b0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [ROW_FIELD_W-1:0] out_cells;
  logic                  out_last;
  logic                  cfg_we       = 1'b0;
  logic                  cfg_index    = CFG_ROW_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata    = '0;

  // smoothing model state: per stage row above, held row and held flag
  logic [ROW_WIDTH_W-1:0] model_width;
  logic [PASS_CNT_W-1:0]  model_passes;
  row_bits_t              wall_above [MAX_PASSES];
  row_bits_t              held_row   [MAX_PASSES];
  logic                   held_valid [MAX_PASSES];

  cas_row_t stage_emit[$];     // rows leaving the stage under evaluation
  cas_row_t cascade_rows[$];   // rows leaving the last active stage
  cas_row_t pending_rows[$];   // smoothed rows still owed by the dut
  cas_row_t got_row;

  // a directed row may carry its expectation by hand
  logic     row_typed = 1'b0;
  cas_row_t typed_row = '0;

  bit long_hold_req = 1'b0;
  int error_count = 0;
  int cycle_count = 0;

  cave_automaton_smoothing_step DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_row_cells (in_row_cells),
    .in_last_row  (in_last_row),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_cells    (out_cells),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // smoothing model
  // ---------------------------------------------------------------------------

  // width code 0 means one column, anything past 64 means 64
  function automatic int active_width();
    if (model_width == 0) return 1;
    if (model_width > MAX_WIDTH) return MAX_WIDTH;
    return int'(model_width);
  endfunction

  function automatic int active_passes();
    if (model_passes > MAX_PASSES) return MAX_PASSES;
    return int'(model_passes);
  endfunction

  function automatic row_bits_t column_mask(int w);
    if (w >= MAX_WIDTH) return '1;
    return (row_bits_t'(1) << w) - row_bits_t'(1);
  endfunction

  // anything off the grid edge reads as wall
  function automatic int wall_at(row_bits_t row, int col, int w);
    if (col < 0 || col >= w) return 1;
    return int'(row[col]);
  endfunction

  // a cell becomes wall when at least WALL_LIMIT of its eight neighbors are walls
  function automatic row_bits_t smooth_pass(row_bits_t up, row_bits_t mid,
                                            row_bits_t down, int w);
    row_bits_t res;
    int        walls;
    res = '0;
    for (int c = 0; c < w; c++) begin
      walls = wall_at(up, c - 1, w) + wall_at(up, c, w) + wall_at(up, c + 1, w)
            + wall_at(mid, c - 1, w) + wall_at(mid, c + 1, w)
            + wall_at(down, c - 1, w) + wall_at(down, c, w) + wall_at(down, c + 1, w);
      if (walls >= WALL_LIMIT) res[c] = 1'b1;
    end
    return res;
  endfunction

  function automatic void clear_stage(int s);
    wall_above[s] = ALL_WALL;
    held_row[s]   = '0;
    held_valid[s] = 1'b0;
  endfunction

  function automatic void reset_model();
    model_width  = ROW_WIDTH_RST;
    model_passes = PASS_CNT_RST;
    for (int s = 0; s < MAX_PASSES; s++) clear_stage(s);
  endfunction

  // push one row into stage s, appending whatever it releases to stage_emit
  function automatic void stage_step(int s, cas_row_t r, int w);
    cas_row_t res;
    if (!held_valid[s]) begin
      if (r.last) begin
        // lone row: border walls above and below
        res.cells = smooth_pass(wall_above[s], r.cells, ALL_WALL, w);
        res.last  = 1'b1;
        stage_emit.push_back(res);
        clear_stage(s);
      end else begin
        held_row[s]   = r.cells;
        held_valid[s] = 1'b1;
      end
    end else begin
      res.cells = smooth_pass(wall_above[s], held_row[s], r.cells, w);
      res.last  = 1'b0;
      stage_emit.push_back(res);
      wall_above[s] = held_row[s];
      held_row[s]   = r.cells;
      if (r.last) begin
        // bottom of grid: flush the held row against the lower border
        res.cells = smooth_pass(wall_above[s], held_row[s], ALL_WALL, w);
        res.last  = 1'b1;
        stage_emit.push_back(res);
        clear_stage(s);
      end
    end
  endfunction

  // run one accepted row through the active stages; results land in cascade_rows
  function automatic void smooth_cascade(row_bits_t cells, logic last);
    cas_row_t head;
    int       w;
    int       p;
    w = active_width();
    p = active_passes();
    head.cells = cells & column_mask(w);
    head.last  = last;
    cascade_rows.delete();
    cascade_rows.push_back(head);
    for (int s = 0; s < p; s++) begin
      stage_emit.delete();
      foreach (cascade_rows[k]) stage_step(s, cascade_rows[k], w);
      cascade_rows = stage_emit;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: register writes, input transfers and result transfers, all sampled
  // at the rising edge before the dut updates anything
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ROW_WIDTH) model_width = cfg_wdata[ROW_WIDTH_W-1:0];
        else model_passes = cfg_wdata[PASS_CNT_W-1:0];
      end
      if (in_valid && in_ready) begin
        smooth_cascade(in_row_cells, in_last_row);
        if (row_typed) pending_rows.push_back(typed_row);
        else foreach (cascade_rows[k]) pending_rows.push_back(cascade_rows[k]);
      end
      if (out_valid && out_ready) begin
        if (pending_rows.size() == 0) begin
          $error("result transfer with nothing pending: out_cells=%h out_last=%b",
                 out_cells, out_last);
          error_count++;
        end else begin
          got_row = pending_rows.pop_front();
          if (out_cells !== got_row.cells) begin
            $error("out_cells mismatch: expected %h, actual %h", got_row.cells, out_cells);
            error_count++;
          end
          if (out_last !== got_row.last) begin
            $error("out_last mismatch: expected %b, actual %b", got_row.last, out_last);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall mode is redrawn after each random span; one long hold-off on
  // request, counted here, to back the cascade up into in_ready
  // ---------------------------------------------------------------------------
  initial begin
    int         mode;
    int         span;
    int         phase;
    logic [7:0] stall_pattern;
    phase = 0;
    forever begin
      mode          = $urandom_range(0, 3);
      span          = $urandom_range(10, 60);
      stall_pattern = 8'($urandom) | 8'h01;
      repeat (span) begin
        @(negedge clk);
        if (long_hold_req) begin
          out_ready <= 1'b0;
          repeat (LONG_HOLD) @(negedge clk);
          long_hold_req = 1'b0;
        end
        phase++;
        case (mode)
          0: out_ready <= 1'b1;                            // no stalls
          1: out_ready <= 1'($urandom_range(0, 1));         // coin flip
          2: out_ready <= ($urandom_range(0, 3) == 0);     // mostly stalled
          default: out_ready <= stall_pattern[phase % 8];  // fixed rhythm
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  // offer one row and hold it until the transfer; bursts with random gaps between
  task automatic send_row(row_bits_t cells, logic last, logic typed, cas_row_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_row_cells <= cells;
    in_last_row  <= last;
    row_typed     = typed;
    typed_row     = want;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid, wait for every owed row, then let rows with no result settle;
  // only cycles with out_ready high count, since a stall can freeze the cascade
  task automatic wait_idle();
    int quiet;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    quiet = 0;
    while (quiet < SETTLE_CYCLES) begin
      @(posedge clk);
      if (out_ready) quiet++;
    end
  endtask

  // write both registers on consecutive cycles
  task automatic set_config(logic [CFG_DATA_W-1:0] width, logic [CFG_DATA_W-1:0] passes);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROW_WIDTH;
    cfg_wdata <= width;
    @(negedge clk);
    cfg_index <= CFG_PASS_COUNT;
    cfg_wdata <= passes;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly narrow rows so edge columns matter, sometimes the clamp cases
  task automatic random_config();
    logic [CFG_DATA_W-1:0] w;
    logic [PASS_CNT_W-1:0] p;
    case ($urandom_range(0, 4))
      0, 1: w = 7'($urandom_range(1, 16));
      2: w = 7'($urandom_range(17, 64));
      default: w = WIDTH_EDGES[$urandom_range(0, 5)];
    endcase
    p = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    set_config(w, {3'($urandom_range(0, 7)), p});
  endtask

  function automatic row_bits_t random_cells();
    row_bits_t a;
    row_bits_t b;
    row_bits_t c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return '0;
      1: return ALL_WALL;
      2: return a & b & c;   // sparse walls
      3: return a | b;       // dense walls
      default: return a;
    endcase
  endfunction

  initial begin
    int       items_sent;
    int       grid_rows;
    cas_row_t want;
    items_sent = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_CFG) begin
        wait_idle();
        set_config(directed_steps[i].width, directed_steps[i].passes);
      end else begin
        want.cells = directed_steps[i].exp_cells;
        want.last  = directed_steps[i].exp_last;
        send_row(directed_steps[i].cells, directed_steps[i].last,
                 directed_steps[i].typed, want);
      end
    end

    // random grids; the receiver's long hold-off lands on a tall first grid,
    // so the sender keeps offering rows until the cascade backs up
    wait_idle();
    long_hold_req = 1'b1;
    want = '0;
    for (int r = 0; r < HOLD_ROWS; r++) begin
      send_row(random_cells(), r == HOLD_ROWS - 1, 1'b0, want);
      items_sent++;
    end
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        random_config();
      end
      grid_rows = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24)
                                              : $urandom_range(1, 10);
      for (int r = 0; r < grid_rows; r++) begin
        // now and then retune in the middle of a grid
        if (r > 0 && $urandom_range(0, 24) == 0) begin
          wait_idle();
          random_config();
        end
        send_row(random_cells(), r == grid_rows - 1, 1'b0, want);
        items_sent++;
      end
    end

    wait_idle();
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
